// File: rtl/lru_record_cache_macros.svh
// Assertion macros used by the checker of the record cache.
`ifndef LRU_RECORD_CACHE_MACROS_SVH
`define LRU_RECORD_CACHE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lru_record_cache: check failed");

// The consequent must hold in the cycle after the antecedent.
`define LRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lru_record_cache: check failed");

`endif

// File: rtl/lrc_pkg.sv
package lrc_pkg;

    localparam int KEY_W      = 31;
    localparam int WORD_W     = 64;
    localparam int CAP_W      = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd15;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_STORE  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd              command;
        logic [KEY_W-1:0]  key;
        logic [WORD_W-1:0] record_data;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] read_data;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_key;
        logic              is_full;
    } t_rsp;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } t_tag;

    typedef struct packed {
        logic             hit;
        logic             insert;
        logic             evict;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

endpackage

// File: rtl/lrc_cell.sv
module lrc_cell
    import lrc_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  t_tag                  i_prev_tag,
    input  logic [DATA_WIDTH-1:0] i_prev_data,
    input  logic                  i_match_up,
    output t_tag                  o_tag,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_match,
    output logic                  o_match_dn
);

    logic                  r_valid;
    logic [KEY_W-1:0]      r_key;
    logic [DATA_WIDTH-1:0] r_data;
    logic                  load;

    // A cell takes its predecessor's entry when the entry in front of it moves down.
    always_comb begin
        o_match    = r_valid && (r_key == i_ctl.key);
        o_match_dn = o_match | i_match_up;
        if (i_ctl.hit) begin
            load = o_match_dn;
        end else if (i_ctl.insert) begin
            load = i_ctl.evict ? r_valid : (r_valid | i_prev_tag.valid);
        end else begin
            load = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_prev_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_key  <= i_prev_tag.key;
            r_data <= i_prev_data;
        end
    end

    assign o_tag  = '{valid: r_valid, key: r_key};
    assign o_data = r_data;

endmodule

// File: rtl/lru_record_cache.sv
// Channel  | Direction | Payload | Handshake
// ---------+-----------+---------+--------------------------
// request  | in        | t_req   | i_in_valid / o_in_ready
// result   | out       | t_rsp   | o_out_valid / i_out_ready
// capacity | in        | 5 bits  | i_cfg_valid / o_cfg_ready
//
// One request is taken per cycle while the skid register is empty; its result is
// registered in the output register, or in the skid register while a result waits.
// Reset clears the valid marks and the occupancy directly; there is no clearing pass.
// An output register and a skid register let a request be taken while a result waits.
// The request side stalls only while both of them are full.
module lru_record_cache
    import lrc_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int DATA_WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_req             i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_rsp             o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    logic [CAP_W-1:0]      r_cap;
    logic [OCC_W-1:0]      r_occ;
    logic                  r_out_valid;
    t_rsp                  r_out;
    logic                  r_skid_valid;
    t_rsp                  r_skid;

    t_tag                  tags      [ENTRIES];
    logic [DATA_WIDTH-1:0] datas     [ENTRIES];
    t_tag                  prev_tags [ENTRIES];
    logic [DATA_WIDTH-1:0] prev_datas[ENTRIES];
    logic [ENTRIES-1:0]    match_vec;
    logic [ENTRIES-1:0]    match_dn;
    logic [ENTRIES-1:0]    match_up;
    logic [ENTRIES-1:0]    last;

    logic                  accept;
    logic                  hit;
    logic                  insert;
    logic                  evict;
    logic [CMP_W-1:0]      cap_eff;
    logic [CMP_W-1:0]      occ_after;
    logic [DATA_WIDTH-1:0] hit_data;
    logic [DATA_WIDTH-1:0] front_data;
    logic [KEY_W-1:0]      lru_key;
    t_cell_ctl             ctl;
    t_rsp                  result;
    logic                  out_free;

    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = !r_skid_valid;
    assign o_cfg_ready = 1'b1;

    generate
        for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
            if (i == 0) begin : g_head
                assign prev_tags[i]  = '{valid: 1'b1, key: i_in.key};
                assign prev_datas[i] = front_data;
            end else begin : g_body
                assign prev_tags[i]  = tags[i-1];
                assign prev_datas[i] = datas[i-1];
            end
            if (i == ENTRIES - 1) begin : g_tail
                assign match_up[i] = 1'b0;
                assign last[i]     = tags[i].valid;
            end else begin : g_inner
                assign match_up[i] = match_dn[i+1];
                assign last[i]     = tags[i].valid & ~tags[i+1].valid;
            end

            lrc_cell #(
                .DATA_WIDTH(DATA_WIDTH)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_prev_tag (prev_tags[i]),
                .i_prev_data(prev_datas[i]),
                .i_match_up (match_up[i]),
                .o_tag      (tags[i]),
                .o_data     (datas[i]),
                .o_match    (match_vec[i]),
                .o_match_dn (match_dn[i])
            );
        end
    endgenerate

    always_comb begin
        hit_data = '0;
        lru_key  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_data = hit_data | (match_vec[i] ? datas[i] : '0);
            lru_key  = lru_key | (last[i] ? tags[i].key : '0);
        end
    end

    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end else begin
            cap_eff = CMP_W'(r_cap);
        end

        hit        = match_dn[0];
        insert     = !hit && (i_in.command == CMD_STORE);
        evict      = insert && (CMP_W'(r_occ) >= cap_eff);
        front_data = (i_in.command == CMD_STORE) ? i_in.record_data[DATA_WIDTH-1:0]
                                                 : hit_data;
        occ_after  = (insert && !evict) ? CMP_W'(r_occ) + CMP_W'(1) : CMP_W'(r_occ);

        ctl.hit    = accept && hit;
        ctl.insert = accept && insert;
        ctl.evict  = evict;
        ctl.key    = i_in.key;

        result.hit         = hit;
        result.read_data   = (hit && i_in.command == CMD_LOOKUP) ? WORD_W'(hit_data) : '0;
        result.evicted     = evict;
        result.evicted_key = evict ? lru_key : '0;
        result.is_full     = occ_after >= cap_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
            r_occ <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (accept && insert && !evict) begin
                r_occ <= r_occ + OCC_W'(1);
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= accept;
            end else begin
                r_out_valid  <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= result;
            end else begin
                r_out  <= result;
            end
        end else if (accept) begin
            r_skid <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/lrc_checker.sv
`include "lru_record_cache_macros.svh"

module lrc_checker
    import lrc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input t_rsp             o_out
);

    `LRC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))
    `LRC_ASSERT_SAME(a_stall_has_result, !o_in_ready, o_out_valid)
    `LRC_ASSERT_SAME(a_hit_no_evict, o_out_valid, !(o_out.hit && o_out.evicted))
    `LRC_ASSERT_SAME(a_miss_zero_data, o_out_valid && !o_out.hit, o_out.read_data == '0)
    `LRC_ASSERT_SAME(a_evict_key_zero, o_out_valid && !o_out.evicted, o_out.evicted_key == '0)

endmodule

bind lru_record_cache lrc_checker u_lrc_checker (.*);

// File: tb/tb_lru_record_cache.sv
module tb_lru_record_cache;
    timeunit 1ns;
    timeprecision 1ps;

    import lrc_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 9;

    // Predicts every result of the cache and holds the results still to come.
    class lru_result_board;
        logic [KEY_W-1:0]  tag_key  [ENTRIES];
        logic [WORD_W-1:0] tag_word [ENTRIES];
        bit                tag_live [ENTRIES];
        int unsigned       tag_rank [ENTRIES];
        int unsigned       live_count;
        logic [CAP_W-1:0]  capacity_reg;
        t_rsp              expected_results[$];
        int                errors;

        function new();
            foreach (tag_live[i]) begin
                tag_live[i] = 1'b0;
                tag_rank[i] = 0;
            end
            live_count   = 0;
            capacity_reg = CAP_RESET;
            errors       = 0;
        endfunction

        function void note_capacity(logic [CAP_W-1:0] value);
            capacity_reg = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void predict_request(t_req req);
            t_rsp        want;
            int          found;
            int          victim;
            int          slot;
            int unsigned limit;
            int unsigned old_rank;
            want  = '0;
            found = -1;
            limit = (capacity_reg < 1) ? 1 :
                    (capacity_reg > ENTRIES) ? ENTRIES : capacity_reg;
            for (int i = 0; i < ENTRIES; i++) begin
                if (found < 0 && tag_live[i] && tag_key[i] == req.key) found = i;
            end
            if (found >= 0) begin
                want.hit = 1'b1;
                if (req.command == CMD_LOOKUP) want.read_data = tag_word[found];
                else tag_word[found] = req.record_data;
                old_rank = tag_rank[found];
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tag_live[i] && tag_rank[i] < old_rank) tag_rank[i]++;
                end
                tag_rank[found] = 0;
            end else if (req.command == CMD_STORE) begin
                if (live_count >= limit || live_count >= ENTRIES) begin
                    victim = -1;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (tag_live[i] && (victim < 0 || tag_rank[i] > tag_rank[victim]))
                            victim = i;
                    end
                    if (victim >= 0) begin
                        want.evicted     = 1'b1;
                        want.evicted_key = tag_key[victim];
                        tag_live[victim] = 1'b0;
                        if (live_count > 0) live_count--;
                    end
                end
                slot = -1;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tag_live[i]) tag_rank[i]++;
                    else if (slot < 0) slot = i;
                end
                if (slot >= 0) begin
                    tag_live[slot] = 1'b1;
                    tag_key[slot]  = req.key;
                    tag_word[slot] = req.record_data;
                    tag_rank[slot] = 0;
                    live_count++;
                end
            end
            want.is_full = (live_count >= limit);
            expected_results = {expected_results, want};
        endfunction

        function void compare_field(string field, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_results[0];
            expected_results.delete(0);
            compare_field("hit", WORD_W'(want.hit), WORD_W'(got.hit));
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("evicted", WORD_W'(want.evicted), WORD_W'(got.evicted));
            compare_field("evicted_key", WORD_W'(want.evicted_key), WORD_W'(got.evicted_key));
            compare_field("is_full", WORD_W'(want.is_full), WORD_W'(got.is_full));
        endfunction
    endclass

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_req             i_in        = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_rsp             o_out;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data  = '0;

    lru_result_board board = new();
    t_req            request_q[$];
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    bit              hold_req      = 1'b0;
    int              hold_left     = 0;
    int              quiet_cycles  = 0;

    lru_record_cache DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // The result side; a long hold-off lets the block fill up and stall its input.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) board.check_result(o_out);
            if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req    = 1'b0;
                hold_left   <= HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL lru_record_cache");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_req make_req(t_cmd cmd, logic [KEY_W-1:0] key,
                                      logic [WORD_W-1:0] word);
        t_req req;
        req.command     = cmd;
        req.key         = key;
        req.record_data = word;
        return req;
    endfunction

    function automatic void add_req(t_req req);
        request_q = {request_q, req};
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic drive_requests();
        t_req req;
        while (request_q.size() > 0) begin
            req = request_q[0];
            request_q.delete(0);
            while ($urandom_range(99) < send_idle_pct) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in       <= req;
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
            board.predict_request(req);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.note_capacity(value);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly keys from a small pool so that hits and evictions are frequent.
    // A lookup followed by a store of the same key mimics a miss and refill.
    task automatic queue_random_requests(int count, int pool_size);
        logic [KEY_W-1:0] pool[32];
        logic [KEY_W-1:0] key;
        int               made;
        int               pick;
        made = 0;
        foreach (pool[i]) pool[i] = KEY_W'($urandom());
        while (made < count) begin
            key  = pool[$urandom_range(pool_size - 1)];
            pick = $urandom_range(99);
            if (pick < 40) begin
                add_req(make_req(CMD_LOOKUP, key, random_word()));
                made++;
            end else if (pick < 75) begin
                add_req(make_req(CMD_STORE, key, random_word()));
                made++;
            end else if (pick < 90) begin
                add_req(make_req(CMD_LOOKUP, key, random_word()));
                add_req(make_req(CMD_STORE, key, random_word()));
                made += 2;
            end else begin
                add_req(make_req(($urandom_range(1) == 1) ? CMD_STORE : CMD_LOOKUP,
                                 KEY_W'($urandom()), random_word()));
                made++;
            end
        end
    endtask

    initial begin
        logic [CAP_W-1:0] capacities[PHASES];
        int               pools[PHASES];
        capacities = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd12, 5'd0, 5'd16, 5'd5};
        pools      = '{24, 6, 30, 3, 3, 16, 12, 20, 8};
        capacities[6] = CAP_W'($urandom_range(31));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_req(make_req(CMD_LOOKUP, '0, '0));
        add_req(make_req(CMD_STORE, '0, '0));
        add_req(make_req(CMD_LOOKUP, '0, '1));
        add_req(make_req(CMD_STORE, '1, '1));
        add_req(make_req(CMD_LOOKUP, '1, '0));
        add_req(make_req(CMD_STORE, '0, '1));
        add_req(make_req(CMD_LOOKUP, '0, '0));
        for (int k = 1; k <= 13; k++)
            add_req(make_req(CMD_STORE, KEY_W'(k), random_word()));
        add_req(make_req(CMD_STORE, 31'h2AAA_AAAA, 64'h5555_5555_5555_5555));
        add_req(make_req(CMD_LOOKUP, '1, '1));
        add_req(make_req(CMD_STORE, 31'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
        add_req(make_req(CMD_LOOKUP, 31'h5555_5555, '0));
        add_req(make_req(CMD_LOOKUP, KEY_W'(1), '0));
        drive_requests();

        for (int ph = 0; ph < PHASES; ph++) begin
            send_idle_pct = (ph < 3) ? 10 : (ph < 6) ? 85 : 0;
            recv_idle_pct = (ph < 3) ? 85 : (ph < 6) ? 10 : 0;
            write_capacity(capacities[ph]);
            if (ph == 1) hold_req = 1'b1;
            queue_random_requests(217, pools[ph]);
            drive_requests();
        end

        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("PASS lru_record_cache");
        end else begin
            $display("FAIL lru_record_cache");
        end
        $finish;
    end
endmodule
